// ===== rtl/rle565_pkg.sv =====
// Package for the RGB565 run-length encoder: shared types and constants.
// Used by every module of the block; depends on nothing.
package rle565_pkg;

	// Longest run that one pair can carry.
	localparam logic [15:0] RUN_MAX = 16'hFFFF;

	// Default depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH_DEF = 4;

	// One run pair as it leaves the block.
	typedef struct packed {
		logic [15:0] len;
		logic [15:0] color;
	} run_pair_t;

	// What one pixel leaves for the back part: a closed run, a final run, or both.
	typedef struct packed {
		logic      closed_valid;
		run_pair_t closed;
		logic      final_valid;
		run_pair_t fin;
	} run_entry_t;

	// Head of the queue as the back part sees it.
	typedef struct packed {
		logic       valid;
		run_entry_t entry;
	} queue_head_t;

	// Truncate a 24-bit pixel to RGB565.
	function automatic logic [15:0] to_565(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		to_565 = {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

// ===== rtl/rle565_front.sv =====
// Front part: accepts pixels, keeps the open run and classifies each pixel.
// Depends on rle565_pkg; pushes run entries into rle565_queue.
module rle565_front import rle565_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	output logic        pix_ready,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        frame_end,
	output logic        push,
	output run_entry_t  push_entry,
	input  logic        queue_full
);

	logic [15:0] cur_color_q;
	logic [15:0] cur_len_q;
	logic [15:0] color;
	logic        extend;
	logic        accept;
	logic [15:0] new_len;
	logic [15:0] new_color;

	assign pix_ready = !queue_full;
	assign accept    = pix_valid && pix_ready;

	// Classify the pixel against the open run.
	always_comb begin
		color  = to_565(red, green, blue);
		extend = (cur_len_q != 16'd0) && (color == cur_color_q) && (cur_len_q != RUN_MAX);
		if (extend) begin
			new_len   = cur_len_q + 16'd1;
			new_color = cur_color_q;
		end else begin
			new_len   = 16'd1;
			new_color = color;
		end
		push_entry.closed_valid = !extend && (cur_len_q != 16'd0);
		push_entry.closed.len   = cur_len_q;
		push_entry.closed.color = cur_color_q;
		push_entry.final_valid  = frame_end;
		push_entry.fin.len      = new_len;
		push_entry.fin.color    = new_color;
		push = accept && (push_entry.closed_valid || frame_end);
	end

	// Open run state; frame end clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_color_q <= 16'd0;
			cur_len_q   <= 16'd0;
		end else if (accept) begin
			if (frame_end) begin
				cur_color_q <= 16'd0;
				cur_len_q   <= 16'd0;
			end else begin
				cur_color_q <= new_color;
				cur_len_q   <= new_len;
			end
		end
	end

endmodule

// ===== rtl/rle565_queue.sv =====
// Short queue of run entries between the front and back parts.
// Depends on rle565_pkg; entries live in a small register array.
module rle565_queue import rle565_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  run_entry_t  push_entry,
	output logic        full,
	input  logic        pop,
	output queue_head_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	run_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/rle565_back.sv =====
// Back part: turns each queued entry into one or two output run pairs.
// Depends on rle565_pkg; reads the head of rle565_queue.
module rle565_back import rle565_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_head_t head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output run_pair_t   out_pair,
	output logic        out_final
);

	logic phase_q;
	logic show_closed;
	logic accept;

	// Closed run goes first; the final run follows in a second request.
	always_comb begin
		show_closed = head.entry.closed_valid && !phase_q;
		out_valid   = head.valid;
		out_pair    = show_closed ? head.entry.closed : head.entry.fin;
		out_final   = !show_closed;
		accept      = out_valid && out_ready;
		pop         = accept && (!show_closed || !head.entry.final_valid);
	end

	// Phase marks that the closed pair of the head entry is already out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (pop) begin
			phase_q <= 1'b0;
		end else if (accept) begin
			phase_q <= 1'b1;
		end
	end

endmodule

// ===== rtl/rgb565_run_length_encoder_core.sv =====
// Top level of the RGB565 run-length encoder.
// Depends on rle565_pkg, rle565_front, rle565_queue and rle565_back.
//
// Channel  Dir  Handshake         Payload
// s_*      in   s_tvalid/tready   tdata: red, green, blue; tlast: frame_end
// m_*      out  m_tvalid/tready   tdata: run_length, run_color; tlast: final_run
//
// One pixel is taken per clock while the queue has room; its results appear
// at the output the cycle after it is accepted, at the earliest.
// A pixel that closes a run and ends the frame yields two pairs, so the back
// part sends the closed pair and then the final pair; the queue absorbs it.
// arst_n clears the open run, the queue and the output phase.
// Either side may stall; the queue of QUEUE_DEPTH entries decouples the two.
module rgb565_run_length_encoder_core import rle565_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // red [7:0], green [15:8], blue [23:16]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // run_length [15:0], run_color [31:16]
	output logic        m_tlast
);

	logic        push;
	run_entry_t  push_entry;
	logic        queue_full;
	logic        pop;
	queue_head_t head;
	run_pair_t   out_pair;

	rle565_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (s_tvalid),
		.pix_ready  (s_tready),
		.red        (s_tdata[7:0]),
		.green      (s_tdata[15:8]),
		.blue       (s_tdata[23:16]),
		.frame_end  (s_tlast),
		.push       (push),
		.push_entry (push_entry),
		.queue_full (queue_full)
	);

	rle565_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head       (head)
	);

	rle565_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pair  (out_pair),
		.out_final (m_tlast)
	);

	assign m_tdata = {out_pair.color, out_pair.len};

endmodule

// ===== dv/rgb565_run_length_encoder_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rgb565_run_length_encoder_core: pixel requests in, run pairs out.
// Depends on rle565_pkg and the encoder RTL; a scoreboard class predicts every run pair.
module rgb565_run_length_encoder_core_test;
	import rle565_pkg::*;

	// One pixel as it travels on s_tdata, red in the lowest byte.
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// One run pair as the encoder should emit it.
	typedef struct {
		logic [15:0] len;
		logic [15:0] color;
		logic        fin;
	} run_result_t;

	// Tracks the open run and keeps the run pairs still owed by the encoder.
	class run_scoreboard;
		logic [15:0] open_color;
		logic [15:0] open_len;
		run_result_t expected_runs[$];
		int mismatches;
		int pixels;
		int pairs;
		int frames;

		function new();
			open_color = '0;
			open_len = '0;
			mismatches = 0;
			pixels = 0;
			pairs = 0;
			frames = 0;
		endfunction

		function logic [15:0] pack565(pixel_t px);
			return {px.red[7:3], px.green[7:2], px.blue[7:3]};
		endfunction

		// An accepted pixel either extends the open run or closes it and opens a new one.
		function void note_pixel(pixel_t px, bit last);
			logic [15:0] c;
			c = pack565(px);
			pixels++;
			if (open_len != 0 && c == open_color && open_len != RUN_MAX) begin
				open_len++;
			end else begin
				if (open_len != 0)
					expected_runs.push_back('{open_len, open_color, 1'b0});
				open_color = c;
				open_len = 16'd1;
			end
			// The frame end flushes whatever run is open and starts from scratch.
			if (last) begin
				expected_runs.push_back('{open_len, open_color, 1'b1});
				open_len = '0;
				open_color = '0;
			end
		endfunction

		function int pending();
			return expected_runs.size();
		endfunction

		task report(string msg);
			if (mismatches < 30)
				$display("MISMATCH at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		// Compares one accepted run pair with the oldest prediction.
		task check_pair(logic [15:0] len, logic [15:0] color, logic fin);
			run_result_t want;
			pairs++;
			if (fin === 1'b1)
				frames++;
			if (expected_runs.size() == 0) begin
				report($sformatf("unexpected run pair length %0d color %h", len, color));
				return;
			end
			want = expected_runs.pop_front();
			if (len !== want.len)
				report($sformatf("run length %0d, expected %0d", len, want.len));
			if (color !== want.color)
				report($sformatf("run color %h, expected %h", color, want.color));
			if (fin !== want.fin)
				report($sformatf("final flag %b, expected %b", fin, want.fin));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // red [7:0], green [15:8], blue [23:16]
	logic        s_tlast;   // frame_end
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // run_length [15:0], run_color [31:16]
	logic        m_tlast;   // final_run

	run_scoreboard sb = new();

	// Idle rates for both sides and the request for a long output stall.
	int tx_gap_pct = 0;
	int rx_stall_pct = 0;
	bit hold_request = 0;
	localparam int HOLD_CYCLES = 200;

	rgb565_run_length_encoder_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// 100 MHz clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(9) == 0)
			return $urandom_range(12, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic pixel_t rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		pixel_t px;
		px.red = r;
		px.green = g;
		px.blue = b;
		return px;
	endfunction

	// A pixel of the given RGB565 color, with random bits below the truncation.
	function automatic pixel_t make_pixel(logic [15:0] c);
		return rgb({c[15:11], 3'($urandom)}, {c[10:5], 2'($urandom)},
			{c[4:0], 3'($urandom)});
	endfunction

	// Offers one pixel request, after an optional gap, and waits until it is taken.
	task automatic send_pixel(pixel_t px, bit last);
		int gap;
		if ($urandom_range(99) < tx_gap_pct) begin
			gap = pick_gap();
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tdata = px;
		s_tlast = last;
		s_tvalid = 1'b1;
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_pixel(px, last);
	endtask

	// A run of pixels of one color; the frame may end on its last pixel.
	task automatic send_run(logic [15:0] c, int count, bit end_frame);
		for (int i = 0; i < count; i++)
			send_pixel(make_pixel(c), end_frame && i == count - 1);
	endtask

	// Output side: random stalls, plus one long hold when asked for.
	initial begin : sink
		int idle;
		idle = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else if (idle > 0) begin
				m_tready = 1'b0;
				idle--;
			end else if ($urandom_range(99) < rx_stall_pct) begin
				m_tready = 1'b0;
				idle = pick_gap() - 1;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Every accepted run pair goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_pair(m_tdata[15:0], m_tdata[31:16], m_tlast);
	end

	// Stimulus: directed cases, back-pressure, then random frames.
	initial begin : stimulus
		int items;
		int len;
		int pick;
		logic [15:0] c;
		logic [15:0] palette [6];

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A one-pixel frame, then runs that differ only below the truncation.
		tx_gap_pct = 30;
		rx_stall_pct = 30;
		send_pixel(rgb(8'h00, 8'h00, 8'h00), 1'b1);
		send_pixel(rgb(8'hFF, 8'hFF, 8'hFF), 1'b0);
		send_pixel(rgb(8'hF8, 8'hFC, 8'hF8), 1'b0);
		send_pixel(rgb(8'h07, 8'h03, 8'h07), 1'b0);
		send_pixel(rgb(8'h00, 8'h00, 8'h00), 1'b1);

		// A color change on the frame's last pixel yields two pairs.
		send_pixel(rgb(8'hFF, 8'h00, 8'h00), 1'b0);
		send_pixel(rgb(8'h00, 8'hFF, 8'h00), 1'b1);

		// The lowest kept bit of each component on its own.
		send_pixel(rgb(8'h08, 8'h00, 8'h00), 1'b0);
		send_pixel(rgb(8'h00, 8'h04, 8'h00), 1'b0);
		send_pixel(rgb(8'h00, 8'h00, 8'h08), 1'b0);
		send_pixel(rgb(8'h80, 8'h80, 8'h80), 1'b1);

		// A black run right after a frame end, where the run state is also zero.
		send_run(16'h0000, 3, 1'b1);

		// Hold the output while every pixel closes a run, so the input must stall.
		tx_gap_pct = 0;
		rx_stall_pct = 20;
		hold_request = 1'b1;
		for (int i = 0; i < 40; i++)
			send_run(16'(i * 37 + 1), 1, i == 39);
		wait (!hold_request);

		// Random frames: runs of recurring colors, some noise pixels and stray frame ends.
		items = 0;
		foreach (palette[k])
			palette[k] = 16'($urandom);
		while (items < 1100) begin
			case ((items / 250) % 3)
				0: begin
					tx_gap_pct = 30;
					rx_stall_pct = 30;
				end
				1: begin
					tx_gap_pct = 0;
					rx_stall_pct = 40;
				end
				default: begin
					tx_gap_pct = 40;
					rx_stall_pct = 0;
				end
			endcase
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_pixel(pixel_t'($urandom), $urandom_range(9) == 0);
				items++;
			end else begin
				pick = $urandom_range(99);
				if (pick < 80)
					len = $urandom_range(1, 6);
				else if (pick < 95)
					len = $urandom_range(7, 30);
				else
					len = $urandom_range(31, 100);
				c = ($urandom_range(4) == 0) ? 16'($urandom) : palette[$urandom_range(5)];
				if ($urandom_range(5) == 0) begin
					send_run(c, len, 1'b1);
					foreach (palette[k])
						palette[k] = 16'($urandom);
				end else begin
					send_run(c, len, 1'b0);
				end
				items += len;
			end
		end
		send_pixel(make_pixel(palette[0]), 1'b1);

		// Drain: wait for every predicted pair, then watch for strays.
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tlast = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Run covered %0d pixels in %0d frames and checked %0d run pairs.",
			sb.pixels, sb.frames, sb.pairs);
		$display("Output was held for %0d cycles once; %0d mismatches.",
			HOLD_CYCLES, sb.mismatches);
		if (sb.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin : watchdog
		#(30_000_000);
		$display("Timeout with %0d run pairs still expected.", sb.pending());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
